### hw/rtl/wbd_pkg.sv
// ----------------------------------------------------------------------------
// wbd_pkg: shared types and constants of the wasm body decoder
// Opcode values, result and error codes, queue entry and result layouts.
// ----------------------------------------------------------------------------
package wbd_pkg;

  // opcode bytes
  localparam logic [7:0] OP_UNREACHABLE = 8'h00;
  localparam logic [7:0] OP_END         = 8'h0b;
  localparam logic [7:0] OP_RETURN      = 8'h0f;
  localparam logic [7:0] OP_CALL        = 8'h10;
  localparam logic [7:0] OP_LOCAL_GET   = 8'h20;
  localparam logic [7:0] OP_LOCAL_SET   = 8'h21;
  localparam logic [7:0] OP_LOCAL_TEE   = 8'h22;
  localparam logic [7:0] OP_I32_CONST   = 8'h41;
  localparam logic [7:0] OP_I64_CONST   = 8'h42;
  localparam logic [7:0] OP_F32_CONST   = 8'h43;
  localparam logic [7:0] OP_F64_CONST   = 8'h44;

  // value type bytes
  localparam logic [7:0] VT_I32 = 8'h7f;
  localparam logic [7:0] VT_I64 = 8'h7e;
  localparam logic [7:0] VT_F32 = 8'h7d;
  localparam logic [7:0] VT_F64 = 8'h7c;

  // LEB group index of the tenth byte
  localparam logic [3:0] LEB_LAST_GROUP = 4'd9;

  // default depth of the byte queue
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  typedef enum logic [3:0] {
    KIND_LOCAL_RUN   = 4'd0,
    KIND_UNREACHABLE = 4'd1,
    KIND_END         = 4'd2,
    KIND_RETURN      = 4'd3,
    KIND_LOCAL_GET   = 4'd4,
    KIND_LOCAL_SET   = 4'd5,
    KIND_LOCAL_TEE   = 4'd6,
    KIND_CONST       = 4'd7,
    KIND_CALL        = 4'd8,
    KIND_ERROR       = 4'd9
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_UNSUPPORTED = 2'd1,
    ERR_BAD_FUNC    = 2'd2,
    ERR_TRUNCATED   = 2'd3
  } err_t;

  // opcode class, decided by the front end
  typedef enum logic [2:0] {
    OC_UNREACHABLE,
    OC_END,
    OC_RETURN,
    OC_ULEB_ARG,
    OC_SLEB_ARG,
    OC_FLOAT_ARG,
    OC_UNSUPPORTED
  } opclass_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       body_start;
    logic       body_last;
  } in_item_t;

  typedef struct packed {
    kind_t              result_kind;
    logic [7:0]         value_type;
    logic signed [63:0] operand_value;
    logic               final_end;
    err_t               error_code;
    logic [31:0]        byte_offset;
  } out_item_t;

  typedef struct packed {
    in_item_t item;
    opclass_t opclass;
  } q_entry_t;

endpackage

### hw/rtl/wasm_body_instruction_decoder.sv
// ----------------------------------------------------------------------------
// wasm_body_instruction_decoder: WebAssembly function body decoder
// Parses the locals prelude and decodes a subset of opcodes, one byte a cycle unless stalled.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload     | direction
//  --------+----------------------+-------------+----------
//  in      | in_valid / in_stall  | in_data     | body bytes into the block
//  out     | out_valid / out_stall| out_data    | decoded results out
//  cfg     | cfg_we               | cfg_data    | function_count write
//
// One byte per cycle while the result side does not stall: every byte is one pass
// of the back end parser, and at most one result leaves per byte. A byte passes
// through a queue slot, then its result goes into the result register.
// Reset clears the queue, the parser state (idle, waiting for body_start) and
// function_count. in_stall rises only when the byte queue is full; the back end
// holds when the result register is full and stalled, so the two sides slip
// against each other by up to QUEUE_DEPTH bytes.
//
module wasm_body_instruction_decoder #(
  // entries in the byte queue between front and back end
  parameter int QUEUE_DEPTH = wbd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  // byte input transactions
  input  logic               in_valid,
  output logic               in_stall,
  input  wbd_pkg::in_item_t  in_data,
  // result output transactions
  output logic               out_valid,
  input  logic               out_stall,
  output wbd_pkg::out_item_t out_data,
  // function_count register
  input  logic               cfg_we,
  input  logic [31:0]        cfg_data
);

  // front end -> queue
  logic              push;
  wbd_pkg::q_entry_t push_entry;
  logic              q_full;
  // queue -> back end
  logic              q_valid;
  logic              q_pop;
  wbd_pkg::q_entry_t q_entry;

  // Front end: accepts a byte whenever the queue has room and tags it with
  // its opcode class, so the parser only looks at a small code.
  wbd_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Decoupling queue.
  wbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_valid),
    .pop_entry  (q_entry)
  );

  // Back end: LEB128 accumulation, prelude run tracking, call bound check and
  // the registered result slot. A byte leaves the queue whenever that slot is
  // free or being taken in the same cycle.
  wbd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### hw/rtl/wbd_front.sv
// ----------------------------------------------------------------------------
// wbd_front: byte intake and opcode classification
// Takes body bytes off the input channel, tags each with its opcode class.
// ----------------------------------------------------------------------------
module wbd_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  wbd_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              push,
  output wbd_pkg::q_entry_t push_entry
);

  wbd_pkg::opclass_t cls;

  always_comb begin
    unique case (in_data.body_byte)
      wbd_pkg::OP_UNREACHABLE: cls = wbd_pkg::OC_UNREACHABLE;
      wbd_pkg::OP_END:         cls = wbd_pkg::OC_END;
      wbd_pkg::OP_RETURN:      cls = wbd_pkg::OC_RETURN;
      wbd_pkg::OP_CALL,
      wbd_pkg::OP_LOCAL_GET,
      wbd_pkg::OP_LOCAL_SET,
      wbd_pkg::OP_LOCAL_TEE:   cls = wbd_pkg::OC_ULEB_ARG;
      wbd_pkg::OP_I32_CONST,
      wbd_pkg::OP_I64_CONST:   cls = wbd_pkg::OC_SLEB_ARG;
      wbd_pkg::OP_F32_CONST,
      wbd_pkg::OP_F64_CONST:   cls = wbd_pkg::OC_FLOAT_ARG;
      default:                 cls = wbd_pkg::OC_UNSUPPORTED;
    endcase
  end

  assign in_stall           = q_full;
  assign push               = in_valid && !q_full;
  assign push_entry.item    = in_data;
  assign push_entry.opclass = cls;

endmodule

### hw/rtl/wbd_queue.sv
// ----------------------------------------------------------------------------
// wbd_queue: short FIFO between front and back end
// Register-based, one write and one read per cycle, occupancy counter.
// ----------------------------------------------------------------------------
module wbd_queue #(
  parameter int DEPTH = wbd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  wbd_pkg::q_entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output wbd_pkg::q_entry_t pop_entry
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  wbd_pkg::q_entry_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == FULL_COUNT);
  assign not_empty = (count != '0);
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

### hw/rtl/wbd_back.sv
// ----------------------------------------------------------------------------
// wbd_back: body parser and result register
// Runs the prelude / opcode state machine, one queued byte per cycle unless out_stall holds the result register.
// ----------------------------------------------------------------------------
module wbd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_data,
  input  logic               q_valid,
  input  wbd_pkg::q_entry_t  q_entry,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output wbd_pkg::out_item_t out_data
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RUN_COUNT,
    PH_RUN_LEN,
    PH_RUN_TYPE,
    PH_OPCODE,
    PH_ULEB_ARG,
    PH_SLEB_ARG,
    PH_FLOAT_ARG
  } phase_t;

  phase_t      phase, phase_next, phase_e;
  logic [63:0] acc, acc_next, acc_e;
  logic [3:0]  grp, grp_next, grp_e, grp_inc;
  logic [7:0]  pend, pend_next;
  logic [31:0] runs, runs_next, runs_dec;
  logic [31:0] run_len, run_len_next;
  logic [31:0] body_off, body_off_next, off_e;
  logic [31:0] op_off, op_off_next;
  logic [31:0] function_count;

  logic        res_valid;
  wbd_pkg::out_item_t res;

  logic [7:0]  b;
  logic        last;
  logic        cont;
  logic        leb_long;
  logic [6:0]  sh7, sh7_sext;
  logic [63:0] acc_leb, acc_sleb, acc_flt;
  logic [31:0] idx;
  logic        flt_done;

  assign q_pop = q_valid && (!out_valid || !out_stall);

  always_comb begin
    b        = q_entry.item.body_byte;
    last     = q_entry.item.body_last;
    cont     = b[7];
    phase_e  = q_entry.item.body_start ? PH_RUN_COUNT : phase;
    acc_e    = q_entry.item.body_start ? '0 : acc;
    grp_e    = q_entry.item.body_start ? '0 : grp;
    off_e    = q_entry.item.body_start ? '0 : body_off;
    grp_inc  = grp_e + 4'd1;
    leb_long = cont && (grp_e == wbd_pkg::LEB_LAST_GROUP);
    sh7      = 7'(grp_e) * 7'd7;
    sh7_sext = sh7 + 7'd7;
    acc_leb  = acc_e | (64'(b[6:0]) << sh7[5:0]);
    acc_sleb = acc_leb;
    // sign fill only on the closing group
    if (!cont && grp_e < wbd_pkg::LEB_LAST_GROUP && b[6]) begin
      acc_sleb = acc_leb | ({64{1'b1}} << sh7_sext[5:0]);
    end
    acc_flt  = acc_e | (64'(b) << {grp_e[2:0], 3'b000});
    idx      = acc_leb[31:0];
    flt_done = (pend == wbd_pkg::OP_F64_CONST) ? (grp_inc == 4'd8) : (grp_inc == 4'd4);

    phase_next    = phase;
    acc_next      = acc;
    grp_next      = grp;
    pend_next     = pend;
    runs_next     = runs;
    runs_dec      = runs - 32'd1;
    run_len_next  = run_len;
    body_off_next = body_off;
    op_off_next   = op_off;
    res_valid     = 1'b0;
    res           = '0;

    if (q_pop && phase_e != PH_IDLE) begin
      phase_next    = phase_e;
      acc_next      = acc_e;
      grp_next      = grp_e;
      body_off_next = (off_e == '1) ? off_e : off_e + 32'd1;

      unique case (phase_e)
        PH_RUN_COUNT: begin
          acc_next = acc_leb;
          grp_next = grp_inc;
          if (cont) begin
            if (leb_long || last) begin
              res_valid            = 1'b1;
              res.result_kind      = wbd_pkg::KIND_ERROR;
              res.error_code       = wbd_pkg::ERR_TRUNCATED;
              res.byte_offset      = off_e;
              phase_next           = PH_IDLE;
            end
          end else begin
            runs_next = acc_leb[31:0];
            acc_next  = '0;
            grp_next  = '0;
            if (acc_leb[31:0] == '0) begin
              phase_next = PH_OPCODE;
            end else if (last) begin
              res_valid       = 1'b1;
              res.result_kind = wbd_pkg::KIND_ERROR;
              res.error_code  = wbd_pkg::ERR_TRUNCATED;
              res.byte_offset = off_e;
              phase_next      = PH_IDLE;
            end else begin
              phase_next = PH_RUN_LEN;
            end
          end
        end
        PH_RUN_LEN: begin
          acc_next = acc_leb;
          grp_next = grp_inc;
          if (leb_long || last) begin
            res_valid       = 1'b1;
            res.result_kind = wbd_pkg::KIND_ERROR;
            res.error_code  = wbd_pkg::ERR_TRUNCATED;
            res.byte_offset = off_e;
            phase_next      = PH_IDLE;
          end else if (!cont) begin
            run_len_next = acc_leb[31:0];
            acc_next     = '0;
            grp_next     = '0;
            phase_next   = PH_RUN_TYPE;
          end
        end
        PH_RUN_TYPE: begin
          runs_next = runs_dec;
          res_valid = 1'b1;
          if (last && runs_dec != '0) begin
            res.result_kind = wbd_pkg::KIND_ERROR;
            res.error_code  = wbd_pkg::ERR_TRUNCATED;
            res.byte_offset = off_e;
            phase_next      = PH_IDLE;
          end else begin
            res.result_kind   = wbd_pkg::KIND_LOCAL_RUN;
            res.value_type    = b;
            res.operand_value = 64'(run_len);
            phase_next        = (runs_dec != '0) ? PH_RUN_LEN : PH_OPCODE;
          end
        end
        PH_OPCODE: begin
          op_off_next = off_e;
          pend_next   = b;
          acc_next    = '0;
          grp_next    = '0;
          unique case (q_entry.opclass)
            wbd_pkg::OC_UNREACHABLE: begin
              res_valid       = 1'b1;
              res.result_kind = wbd_pkg::KIND_UNREACHABLE;
            end
            wbd_pkg::OC_END: begin
              res_valid       = 1'b1;
              res.result_kind = wbd_pkg::KIND_END;
              res.final_end   = last;
            end
            wbd_pkg::OC_RETURN: begin
              res_valid       = 1'b1;
              res.result_kind = wbd_pkg::KIND_RETURN;
            end
            wbd_pkg::OC_ULEB_ARG, wbd_pkg::OC_SLEB_ARG, wbd_pkg::OC_FLOAT_ARG: begin
              if (last) begin
                res_valid       = 1'b1;
                res.result_kind = wbd_pkg::KIND_ERROR;
                res.error_code  = wbd_pkg::ERR_TRUNCATED;
                res.byte_offset = off_e;
                phase_next      = PH_IDLE;
              end else if (q_entry.opclass == wbd_pkg::OC_ULEB_ARG) begin
                phase_next = PH_ULEB_ARG;
              end else if (q_entry.opclass == wbd_pkg::OC_SLEB_ARG) begin
                phase_next = PH_SLEB_ARG;
              end else begin
                phase_next = PH_FLOAT_ARG;
              end
            end
            default: begin
              res_valid         = 1'b1;
              res.result_kind   = wbd_pkg::KIND_ERROR;
              res.error_code    = wbd_pkg::ERR_UNSUPPORTED;
              res.operand_value = 64'(b);
              res.byte_offset   = off_e;
              phase_next        = PH_IDLE;
            end
          endcase
        end
        PH_ULEB_ARG: begin
          acc_next = acc_leb;
          grp_next = grp_inc;
          if (leb_long || (cont && last)) begin
            res_valid       = 1'b1;
            res.result_kind = wbd_pkg::KIND_ERROR;
            res.error_code  = wbd_pkg::ERR_TRUNCATED;
            res.byte_offset = op_off;
            phase_next      = PH_IDLE;
          end else if (!cont) begin
            res_valid  = 1'b1;
            phase_next = PH_OPCODE;
            if (pend == wbd_pkg::OP_CALL) begin
              res.operand_value = 64'(idx);
              if (idx >= function_count) begin
                res.result_kind = wbd_pkg::KIND_ERROR;
                res.error_code  = wbd_pkg::ERR_BAD_FUNC;
                res.byte_offset = op_off;
                phase_next      = PH_IDLE;
              end else begin
                res.result_kind = wbd_pkg::KIND_CALL;
              end
            end else begin
              res.operand_value = 64'(idx);
              if (pend == wbd_pkg::OP_LOCAL_GET) begin
                res.result_kind = wbd_pkg::KIND_LOCAL_GET;
              end else if (pend == wbd_pkg::OP_LOCAL_SET) begin
                res.result_kind = wbd_pkg::KIND_LOCAL_SET;
              end else begin
                res.result_kind = wbd_pkg::KIND_LOCAL_TEE;
              end
            end
          end
        end
        PH_SLEB_ARG: begin
          acc_next = acc_sleb;
          grp_next = grp_inc;
          if (leb_long || (cont && last)) begin
            res_valid       = 1'b1;
            res.result_kind = wbd_pkg::KIND_ERROR;
            res.error_code  = wbd_pkg::ERR_TRUNCATED;
            res.byte_offset = op_off;
            phase_next      = PH_IDLE;
          end else if (!cont) begin
            res_valid         = 1'b1;
            res.result_kind   = wbd_pkg::KIND_CONST;
            res.value_type    = (pend == wbd_pkg::OP_I32_CONST) ? wbd_pkg::VT_I32
                                                                : wbd_pkg::VT_I64;
            res.operand_value = acc_sleb;
            phase_next        = PH_OPCODE;
          end
        end
        PH_FLOAT_ARG: begin
          acc_next = acc_flt;
          grp_next = grp_inc;
          if (flt_done) begin
            res_valid       = 1'b1;
            res.result_kind = wbd_pkg::KIND_CONST;
            phase_next      = PH_OPCODE;
            if (pend == wbd_pkg::OP_F64_CONST) begin
              res.value_type    = wbd_pkg::VT_F64;
              res.operand_value = acc_flt;
            end else begin
              res.value_type    = wbd_pkg::VT_F32;
              res.operand_value = {{32{acc_flt[31]}}, acc_flt[31:0]};
            end
          end else if (last) begin
            res_valid       = 1'b1;
            res.result_kind = wbd_pkg::KIND_ERROR;
            res.error_code  = wbd_pkg::ERR_TRUNCATED;
            res.byte_offset = op_off;
            phase_next      = PH_IDLE;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase

      if (last) begin
        phase_next = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      acc            <= '0;
      grp            <= '0;
      pend           <= '0;
      runs           <= '0;
      run_len        <= '0;
      body_off       <= '0;
      op_off         <= '0;
      function_count <= '0;
      out_valid      <= 1'b0;
    end else begin
      phase    <= phase_next;
      acc      <= acc_next;
      grp      <= grp_next;
      pend     <= pend_next;
      runs     <= runs_next;
      run_len  <= run_len_next;
      body_off <= body_off_next;
      op_off   <= op_off_next;
      if (cfg_we) begin
        function_count <= cfg_data;
      end
      if (q_pop) begin
        out_valid <= res_valid;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (q_pop && res_valid) begin
        out_data <= res;
      end
    end
  end

endmodule

### test/wasm_body_instruction_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wasm_body_instruction_decoder_tb: self-checking bench for the body decoder
// Feeds function bodies byte by byte. The bodies are directed corner cases,
// then random well-formed bodies mixed with cut-short, restarted and garbage
// ones. Every decoded result is predicted by an in-bench decoder and checked.
// ----------------------------------------------------------------------------
module wasm_body_instruction_decoder_tb;
  import wbd_pkg::*;

  // a transaction-free stretch this long means the block has hung
  localparam int QUIET_LIMIT = 1000;
  // cycles to let bytes with no result drain through the queue and back end
  localparam int DRAIN_CYCLES = 16;

  // parser phases of the predictor
  typedef enum logic [2:0] {
    DS_IDLE, DS_RUN_COUNT, DS_RUN_LEN, DS_RUN_TYPE,
    DS_OPCODE, DS_ULEB, DS_SLEB, DS_FLOAT
  } dec_state_e;

  // outcome of feeding one byte to a LEB128 accumulator
  typedef enum logic [1:0] {GRP_MORE, GRP_DONE, GRP_LONG} leb_step_e;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_we = 1'b0;
  logic [31:0] cfg_data = '0;

  wasm_body_instruction_decoder u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the parser and of function_count
  // --------------------------------------------------------------------------
  dec_state_e  dec_phase = DS_IDLE;
  logic [63:0] dec_acc = '0;
  int          dec_shift = 0;
  logic [7:0]  dec_op = '0;
  logic [31:0] dec_runs = '0;
  logic [31:0] dec_run_len = '0;
  logic [31:0] dec_offset = '0;
  int          dec_float_n = 0;
  logic [31:0] dec_op_offset = '0;
  logic [31:0] dec_func_count = '0;   // matches the register's reset value

  out_item_t   decoded_q[$];          // decoded results not yet seen at the output
  int          sent_bytes = 0;        // byte transactions accepted so far
  int          failures = 0;
  int          quiet_cycles = 0;
  bit          in_gaps = 1'b1;        // random idle bursts on the byte side
  bit          out_gaps = 1'b1;       // random stall bursts on the result side
  int          stall_left = 0;
  logic [7:0]  body_q[$];             // body under construction
  out_item_t   head;

  function automatic void leb_clear();
    dec_acc = '0;
    dec_shift = 0;
  endfunction

  function automatic leb_step_e take_uleb(logic [7:0] b);
    dec_acc |= 64'(b[6:0]) << (dec_shift & 63);
    if (!b[7]) return GRP_DONE;
    dec_shift += 7;
    return (dec_shift > 63) ? GRP_LONG : GRP_MORE;
  endfunction

  // signed LEB: sign-extend from the last group unless all 64 bits are filled
  function automatic leb_step_e take_sleb(logic [7:0] b);
    dec_acc |= 64'(b[6:0]) << (dec_shift & 63);
    dec_shift += 7;
    if (!b[7]) begin
      if (dec_shift < 64 && b[6]) dec_acc |= {64{1'b1}} << dec_shift;
      return GRP_DONE;
    end
    return (dec_shift > 63) ? GRP_LONG : GRP_MORE;
  endfunction

  function automatic void push_result(kind_t k, logic [7:0] vt, logic [63:0] val,
                                      logic fin, err_t e, logic [31:0] off);
    out_item_t r;
    r.result_kind   = k;
    r.value_type    = vt;
    r.operand_value = val;
    r.final_end     = fin;
    r.error_code    = e;
    r.byte_offset   = off;
    decoded_q.push_back(r);
  endfunction

  // any error drops the parser back to idle until the next body_start
  function automatic void push_error(err_t e, logic [63:0] val, logic [31:0] off);
    dec_phase = DS_IDLE;
    push_result(KIND_ERROR, 8'h00, val, 1'b0, e, off);
  endfunction

  // Advance the predictor by one accepted byte, queueing any result it yields.
  task automatic decode_byte(in_item_t item);
    logic [7:0]  b;
    logic        l;
    logic [31:0] off;
    logic [31:0] idx;
    logic [63:0] val;
    leb_step_e   st;
    int          need;
    b = item.body_byte;
    l = item.body_last;
    if (item.body_start) begin
      dec_phase = DS_RUN_COUNT;
      dec_offset = '0;
      leb_clear();
      dec_op = '0;
      dec_runs = '0;
      dec_run_len = '0;
      dec_float_n = 0;
      dec_op_offset = '0;
    end
    if (dec_phase == DS_IDLE) return;
    off = dec_offset;

    case (dec_phase)
      DS_RUN_COUNT: begin
        st = take_uleb(b);
        if (st == GRP_LONG || (st == GRP_MORE && l)) begin
          push_error(ERR_TRUNCATED, '0, off);
        end else if (st == GRP_DONE) begin
          dec_runs = dec_acc[31:0];
          leb_clear();
          if (dec_runs == 0) dec_phase = DS_OPCODE;
          else if (l) push_error(ERR_TRUNCATED, '0, off);
          else dec_phase = DS_RUN_LEN;
        end
      end
      DS_RUN_LEN: begin
        // the type byte must still follow, so any last byte here is a cut
        st = take_uleb(b);
        if (st == GRP_LONG || l) begin
          push_error(ERR_TRUNCATED, '0, off);
        end else if (st == GRP_DONE) begin
          dec_run_len = dec_acc[31:0];
          leb_clear();
          dec_phase = DS_RUN_TYPE;
        end
      end
      DS_RUN_TYPE: begin
        dec_runs--;
        if (l && dec_runs != 0) begin
          push_error(ERR_TRUNCATED, '0, off);
        end else begin
          push_result(KIND_LOCAL_RUN, b, {32'h0, dec_run_len}, 1'b0, ERR_NONE, '0);
          dec_phase = (dec_runs != 0) ? DS_RUN_LEN : DS_OPCODE;
        end
      end
      DS_OPCODE: begin
        dec_op_offset = off;
        dec_op = b;
        leb_clear();
        dec_float_n = 0;
        case (b)
          OP_UNREACHABLE: push_result(KIND_UNREACHABLE, 8'h00, '0, 1'b0, ERR_NONE, '0);
          OP_END:         push_result(KIND_END, 8'h00, '0, l, ERR_NONE, '0);
          OP_RETURN:      push_result(KIND_RETURN, 8'h00, '0, 1'b0, ERR_NONE, '0);
          OP_CALL, OP_LOCAL_GET, OP_LOCAL_SET, OP_LOCAL_TEE: begin
            if (l) push_error(ERR_TRUNCATED, '0, off);
            else dec_phase = DS_ULEB;
          end
          OP_I32_CONST, OP_I64_CONST: begin
            if (l) push_error(ERR_TRUNCATED, '0, off);
            else dec_phase = DS_SLEB;
          end
          OP_F32_CONST, OP_F64_CONST: begin
            if (l) push_error(ERR_TRUNCATED, '0, off);
            else dec_phase = DS_FLOAT;
          end
          default: push_error(ERR_UNSUPPORTED, {56'h0, b}, off);
        endcase
      end
      DS_ULEB: begin
        // operand errors point back at the opcode, not the current byte
        st = take_uleb(b);
        if (st == GRP_LONG || (st == GRP_MORE && l)) begin
          push_error(ERR_TRUNCATED, '0, dec_op_offset);
        end else if (st == GRP_DONE) begin
          idx = dec_acc[31:0];
          dec_phase = DS_OPCODE;
          case (dec_op)
            OP_CALL: begin
              if (idx >= dec_func_count) push_error(ERR_BAD_FUNC, {32'h0, idx}, dec_op_offset);
              else push_result(KIND_CALL, 8'h00, {32'h0, idx}, 1'b0, ERR_NONE, '0);
            end
            OP_LOCAL_GET: push_result(KIND_LOCAL_GET, 8'h00, {32'h0, idx}, 1'b0, ERR_NONE, '0);
            OP_LOCAL_SET: push_result(KIND_LOCAL_SET, 8'h00, {32'h0, idx}, 1'b0, ERR_NONE, '0);
            default:      push_result(KIND_LOCAL_TEE, 8'h00, {32'h0, idx}, 1'b0, ERR_NONE, '0);
          endcase
        end
      end
      DS_SLEB: begin
        st = take_sleb(b);
        if (st == GRP_LONG || (st == GRP_MORE && l)) begin
          push_error(ERR_TRUNCATED, '0, dec_op_offset);
        end else if (st == GRP_DONE) begin
          dec_phase = DS_OPCODE;
          push_result(KIND_CONST, (dec_op == OP_I32_CONST) ? VT_I32 : VT_I64, dec_acc,
                      1'b0, ERR_NONE, '0);
        end
      end
      DS_FLOAT: begin
        need = (dec_op == OP_F32_CONST) ? 4 : 8;
        dec_acc |= 64'(b) << (8 * (dec_float_n & 7));
        dec_float_n++;
        if (dec_float_n >= need) begin
          dec_phase = DS_OPCODE;
          if (need == 4) begin
            val = {{32{dec_acc[31]}}, dec_acc[31:0]};
            push_result(KIND_CONST, VT_F32, val, 1'b0, ERR_NONE, '0);
          end else begin
            push_result(KIND_CONST, VT_F64, dec_acc, 1'b0, ERR_NONE, '0);
          end
        end else if (l) begin
          push_error(ERR_TRUNCATED, '0, dec_op_offset);
        end
      end
      default: dec_phase = DS_IDLE;
    endcase

    if (l) dec_phase = DS_IDLE;
    if (dec_offset != 32'hffff_ffff) dec_offset++;
  endtask

  // --------------------------------------------------------------------------
  // Byte side: one transaction per call, optional idle burst ahead of it.
  // Valid stays high between back-to-back bytes; the payload holds while stalled.
  // --------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b, logic s, logic l);
    in_item_t item;
    item.body_byte  = b;
    item.body_start = s;
    item.body_last  = l;
    if (in_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    sent_bytes++;
    decode_byte(item);
  endtask

  // Send the first cut bytes of body_q; body_last only if asked for.
  task automatic send_body(int cut, bit with_last);
    for (int i = 0; i < cut; i++)
      send_byte(body_q[i], i == 0, with_last && i == cut - 1);
  endtask

  // Drop valid, wait for every predicted result, then let silent bytes drain.
  task automatic settle();
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // function_count is only written with the block idle
  task automatic set_func_count(logic [31:0] count);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= count;
    @(posedge clk);
    cfg_we <= 1'b0;
    dec_func_count = count;
  endtask

  // --------------------------------------------------------------------------
  // Body builders
  // --------------------------------------------------------------------------
  // pad adds redundant zero groups, which is how over-long encodings are made
  function automatic void add_uleb(logic [63:0] v, int pad);
    logic [6:0] grp[$];
    do begin
      grp.push_back(v[6:0]);
      v = v >> 7;
    end while (v != 0);
    repeat (pad) grp.push_back(7'h00);
    foreach (grp[i]) body_q.push_back({i < grp.size() - 1, grp[i]});
  endfunction

  function automatic void add_sleb(logic [63:0] v, int pad);
    logic [6:0]  grp[$];
    logic [63:0] rest;
    bit          done;
    do begin
      grp.push_back(v[6:0]);
      rest = $signed(v) >>> 7;
      done = (rest == '0 && !v[6]) || (rest == '1 && v[6]);
      v = rest;
    end while (!done);
    repeat (pad) grp.push_back({7{v[63]}});
    foreach (grp[i]) body_q.push_back({i < grp.size() - 1, grp[i]});
  endfunction

  function automatic logic [63:0] rand_wide();
    return {$urandom, $urandom} >> $urandom_range(0, 63);
  endfunction

  function automatic logic [63:0] rand_signed();
    logic [63:0] v;
    v = rand_wide();
    return $urandom_range(0, 1) ? ~v : v;
  endfunction

  // mostly minimal LEBs; a few padded, some of those past ten bytes
  function automatic int pick_pad();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 10);
  endfunction

  function automatic logic [7:0] pick_value_type();
    case ($urandom_range(0, 4))
      0: return VT_I32;
      1: return VT_I64;
      2: return VT_F32;
      3: return VT_F64;
      default: return 8'($urandom);
    endcase
  endfunction

  // call targets cluster on the function_count boundary
  function automatic logic [63:0] pick_call_index();
    case ($urandom_range(0, 4))
      0: return {32'h0, dec_func_count - 32'd1};
      1: return {32'h0, dec_func_count};
      2: return {32'h0, 32'($urandom_range(0, dec_func_count))};
      3: return {32'h0, $urandom};
      default: return rand_wide();   // upper bits are dropped by the block
    endcase
  endfunction

  function automatic void add_random_op();
    logic [63:0] v;
    case ($urandom_range(0, 12))
      0: body_q.push_back(OP_UNREACHABLE);
      1: body_q.push_back(OP_RETURN);
      2: body_q.push_back(OP_END);
      3: begin body_q.push_back(OP_LOCAL_GET); add_uleb(rand_wide(), pick_pad()); end
      4: begin body_q.push_back(OP_LOCAL_SET); add_uleb(rand_wide(), pick_pad()); end
      5: begin body_q.push_back(OP_LOCAL_TEE); add_uleb(rand_wide(), pick_pad()); end
      6, 7: begin
        body_q.push_back(OP_CALL);
        add_uleb(pick_call_index(), pick_pad());
      end
      8: begin
        v = rand_signed();
        if ($urandom_range(0, 7) != 0) v = {{32{v[31]}}, v[31:0]};
        body_q.push_back(OP_I32_CONST);
        add_sleb(v, pick_pad());
      end
      9: begin body_q.push_back(OP_I64_CONST); add_sleb(rand_signed(), pick_pad()); end
      10: begin
        body_q.push_back(OP_F32_CONST);
        repeat (4) body_q.push_back(8'($urandom));
      end
      11: begin
        body_q.push_back(OP_F64_CONST);
        repeat (8) body_q.push_back(8'($urandom));
      end
      default: body_q.push_back(8'($urandom));   // nearly always unsupported
    endcase
  endfunction

  // prelude of 0..3 runs, a handful of opcodes, usually closed by end
  function automatic void build_random_body();
    int nruns;
    body_q.delete();
    nruns = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3);
    add_uleb(64'(nruns), pick_pad());
    repeat (nruns) begin
      add_uleb(rand_wide(), pick_pad());
      body_q.push_back(pick_value_type());
    end
    repeat ($urandom_range(1, 8)) add_random_op();
    if ($urandom_range(0, 9) != 0) body_q.push_back(OP_END);
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_locals_prelude();
    // an empty run, then a run of the largest 32-bit length
    body_q = '{8'h02, 8'h00, VT_I32};
    add_uleb(64'h0000_0000_ffff_ffff, 0);
    body_q = {body_q, VT_F64, OP_END};
    send_body(body_q.size(), 1'b1);
    // the body may end right on the last run type
    body_q = '{8'h01, 8'h03, VT_F32};
    send_body(body_q.size(), 1'b1);
  endtask

  task automatic test_control_and_locals();
    body_q = '{8'h00, OP_UNREACHABLE, OP_RETURN, OP_END, OP_LOCAL_GET, 8'h00, OP_LOCAL_SET};
    add_uleb(64'h0000_0000_ffff_ffff, 0);
    body_q.push_back(OP_LOCAL_TEE);
    add_uleb(64'h1_0000_0005, 0);      // only the low 32 bits of an index count
    // no closing end: the body just stops after the tee
    send_body(body_q.size(), 1'b1);
  endtask

  task automatic test_constants();
    body_q = '{8'h00, OP_I32_CONST, 8'h7f, OP_I32_CONST};
    add_sleb(64'hffff_ffff_8000_0000, 0);
    body_q.push_back(OP_I64_CONST);
    add_sleb(64'h8000_0000_0000_0000, 0);
    body_q.push_back(OP_I64_CONST);
    add_sleb(64'h7fff_ffff_ffff_ffff, 0);
    // f32 with the sign bit set comes back sign-extended
    body_q = {body_q, OP_F32_CONST, 8'h00, 8'h00, 8'h00, 8'h80};
    body_q = {body_q, OP_F64_CONST, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
    body_q.push_back(OP_END);
    send_body(body_q.size(), 1'b1);
  endtask

  task automatic test_call_bounds();
    // function_count is still zero from reset: every call is out of range
    body_q = '{8'h00, OP_CALL, 8'h00};
    send_body(body_q.size(), 1'b1);
    set_func_count(32'd8);
    body_q = '{8'h00, OP_CALL, 8'h07, OP_CALL, 8'h08, OP_END};
    send_body(body_q.size(), 1'b1);
    set_func_count(32'hffff_ffff);
    body_q = '{8'h00, OP_CALL};
    add_uleb(64'h0000_0000_ffff_fffe, 0);
    body_q.push_back(OP_CALL);
    add_uleb(64'h0000_0000_ffff_ffff, 0);
    send_body(body_q.size(), 1'b1);
  endtask

  task automatic test_malformed_bodies();
    // unsupported opcode; the end after it is ignored
    body_q = '{8'h00, 8'hff, OP_END};
    send_body(body_q.size(), 1'b1);
    // eleven-byte run count, then an eleven-byte local index
    body_q.delete();
    add_uleb(64'd0, 10);
    send_body(body_q.size(), 1'b1);
    body_q = '{8'h00, OP_LOCAL_GET};
    add_uleb(64'd1, 10);
    send_body(body_q.size(), 1'b1);
    // prelude cut: after the count, after a length, with a run still owed
    body_q = '{8'h01};
    send_body(1, 1'b1);
    body_q = '{8'h01, 8'h05};
    send_body(2, 1'b1);
    body_q = '{8'h02, 8'h01, VT_I64};
    send_body(3, 1'b1);
    // operand-taking opcode as the last byte, and a short f64
    body_q = '{8'h00, OP_I64_CONST};
    send_body(2, 1'b1);
    body_q = '{8'h00, OP_F64_CONST, 8'h01, 8'h02};
    send_body(4, 1'b1);
    // unfinished index, then a new body restarts silently
    body_q = '{8'h00, OP_LOCAL_GET, 8'h80};
    send_body(3, 1'b0);
    body_q = '{8'h00};
    send_body(1, 1'b1);
    // bytes with no body open produce nothing
    send_byte(OP_UNREACHABLE, 1'b0, 1'b0);
    send_byte(OP_END, 1'b0, 1'b1);
  endtask

  // Mostly well-formed bodies with random content; the rest is cut short,
  // left open for a restart, random garbage, or stray bytes.
  task automatic test_random_bodies(int target);
    int stop_at;
    int pick;
    stop_at = sent_bytes + target;
    while (sent_bytes < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 1'($urandom));
      end else if (pick < 12) begin
        body_q.delete();
        repeat ($urandom_range(1, 6)) body_q.push_back(8'($urandom));
        send_body(body_q.size(), 1'b1);
      end else begin
        build_random_body();
        if (pick < 22) send_body($urandom_range(1, body_q.size()), 1'b1);
        else if (pick < 30) send_body(body_q.size(), 1'b0);
        else send_body(body_q.size(), 1'b1);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall bursts, checked on every transaction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || !out_gaps) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 9);
      out_stall  <= 1'b1;
    end
  end

  task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      failures++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        failures++;
        $display("%0t ns: result with nothing expected, expected none, actual %p",
                 $time, out_data);
      end else begin
        head = decoded_q.pop_front();
        check_field("result_kind", head.result_kind, out_data.result_kind);
        check_field("value_type", head.value_type, out_data.value_type);
        check_field("operand_value", head.operand_value, out_data.operand_value);
        check_field("final_end", head.final_end, out_data.final_end);
        check_field("error_code", head.error_code, out_data.error_code);
        check_field("byte_offset", head.byte_offset, out_data.byte_offset);
      end
    end
  end

  // watchdog: cycles in which neither channel completes a transaction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("%0t ns: watchdog, no transaction for %0d cycles", $time, QUIET_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_locals_prelude();
    test_control_and_locals();
    test_constants();
    test_call_bounds();
    test_malformed_bodies();

    set_func_count(32'd16);
    test_random_bodies(220);
    set_func_count(32'hffff_ffff);
    test_random_bodies(160);
    set_func_count($urandom);
    test_random_bodies(120);

    // closing stretch at full rate on both sides
    in_gaps  = 1'b0;
    out_gaps = 1'b0;
    set_func_count(32'd0);
    test_random_bodies(160);

    settle();
    if (failures == 0 && decoded_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/wbd_pkg.sv
hw/rtl/wbd_front.sv
hw/rtl/wbd_queue.sv
hw/rtl/wbd_back.sv
hw/rtl/wasm_body_instruction_decoder.sv
test/wasm_body_instruction_decoder_tb.sv
